### rtl/masked_byte_pattern_search_defines.svh
// ---------------------------------------------------------------------------
// Masked byte pattern search: assertion macros
// Shared property wrappers for the checker; clock clk, reset rst_n.
// ---------------------------------------------------------------------------
`ifndef MASKED_BYTE_PATTERN_SEARCH_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MBPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MBPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mbps_pkg.sv
// ---------------------------------------------------------------------------
// mbps_pkg
// Constants, register indexes and shared types of the pattern search.
// ---------------------------------------------------------------------------
`default_nettype none

package mbps_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int PAT_BYTES   = 8;   // bytes held in the pattern register
  localparam int LEN_W       = 4;
  localparam int CNT_W       = 25;
  localparam int ADDR_W      = 32;
  localparam int LIMIT_W     = 24;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int SEL_W       = 7;   // room for lengths and cell indexes

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN = 3'd0,
    REG_CARE    = 3'd1,
    REG_LENGTH  = 3'd2,
    REG_BASE    = 3'd3,
    REG_LIMIT   = 3'd4
  } cfg_reg_t;

  // Compare settings broadcast to every cell.
  typedef struct packed {
    logic [8*PAT_BYTES-1:0] pattern;
    logic [PAT_BYTES-1:0]   care;
    logic [LEN_W-1:0]       len_eff;
    logic                   all_wild;
  } match_cfg_t;

endpackage

`default_nettype wire

### rtl/mbps_cell.sv
// ---------------------------------------------------------------------------
// mbps_cell
// One window byte: stores it, hands it on, checks it against its pattern byte.
// ---------------------------------------------------------------------------
`default_nettype none

module mbps_cell import mbps_pkg::*; (
  input  wire logic             clk,
  input  wire logic             shift_en,
  input  wire logic             flush,     // load zero instead of the neighbour's byte
  input  wire logic [IDX_W-1:0] idx,
  input  wire match_cfg_t       cfg,
  input  wire logic [7:0]       byte_in,
  output logic      [7:0]       byte_q,
  output logic                  ok
);

  logic [7:0]       byte_r;
  logic [7:0]       byte_nxt;
  logic [SEL_W-1:0] k;
  logic             in_use;
  logic [2:0]       ksel;

  assign byte_nxt = flush ? 8'h00 : byte_in;

  // Position in the pattern: the oldest window byte meets pattern byte 0.
  assign in_use = SEL_W'(idx) < SEL_W'(cfg.len_eff);
  assign k      = SEL_W'(cfg.len_eff) - SEL_W'(1) - SEL_W'(idx);
  assign ksel   = k[2:0];

  always_comb begin
    ok = 1'b1;
    if (in_use && !cfg.all_wild && (k < SEL_W'(PAT_BYTES)) && cfg.care[ksel]) begin
      ok = (byte_nxt == cfg.pattern[{ksel, 3'b000} +: 8]);
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_nxt;
    end
  end

  assign byte_q = byte_r;

endmodule

`default_nettype wire

### rtl/masked_byte_pattern_search.sv
// ---------------------------------------------------------------------------
// masked_byte_pattern_search
// Streams region bytes through a chain of window cells and reports the first
// start offset at which the masked pattern matches, or that none did.
// ---------------------------------------------------------------------------
//
//   channel | handshake             | payload
//   --------+-----------------------+-----------------------------------------
//   in_     | in_valid / in_ready   | data_byte, first_byte, last_byte
//   out_    | out_valid / out_ready | found, match_address
//   cfg_    | cfg_we                | cfg_index, cfg_data (64 bits)
//
// One byte word per cycle while in_ready is high; the window compare runs
// across all cells in parallel, so the result word appears the cycle after
// the deciding byte. in_ready only drops while a result word sits unclaimed
// in the output register and out_ready is low.
// Reset (rst_n, synchronous): search idle, output empty, registers to
// their reset values. No clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module masked_byte_pattern_search import mbps_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // byte stream
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic              in_first_byte,
  input  wire logic              in_last_byte,
  // result
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_found,
  output logic [ADDR_W-1:0]      out_match_address,
  // configuration
  input  wire logic              cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  // configuration registers
  logic [8*PAT_BYTES-1:0] pattern_r;
  logic [PAT_BYTES-1:0]   care_r;
  logic [LEN_W-1:0]       length_r;
  logic [ADDR_W-1:0]      base_r;
  logic [LIMIT_W-1:0]     limit_r;

  // search state
  logic [CNT_W-1:0]       cnt_r, cnt_nxt, cnt_base;
  logic                   done_r;

  // output register
  logic                   out_valid_r;
  logic                   found_r;
  logic [ADDR_W-1:0]      addr_r;

  logic                   in_fire;
  logic                   active;
  logic                   shift_en;
  match_cfg_t             mcfg;
  logic [LEN_W-1:0]       len_eff;
  logic [CNT_W-1:0]       len_ext;
  logic [CNT_W-1:0]       start;
  logic [CNT_W:0]         start_p1;
  logic                   have_win;
  logic                   in_limit;
  logic                   win_ok;
  logic                   hit;
  logic                   miss;

  logic [7:0]             cell_in [MAX_PATTERN];
  logic [7:0]             cell_q  [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] cell_ok;

  // --- config port: writes beyond the register list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      care_r    <= '0;
      length_r  <= LEN_W'(1);
      base_r    <= '0;
      limit_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN: pattern_r <= cfg_data[8*PAT_BYTES-1:0];
        REG_CARE:    care_r    <= cfg_data[PAT_BYTES-1:0];
        REG_LENGTH:  length_r  <= cfg_data[LEN_W-1:0];
        REG_BASE:    base_r    <= cfg_data[ADDR_W-1:0];
        REG_LIMIT:   limit_r   <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // --- effective length: zero acts as one wildcard, long ones saturate
  always_comb begin
    len_eff = length_r;
    if (length_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (int'(length_r) > MAX_PATTERN) begin
      len_eff = LEN_W'(MAX_PATTERN);
    end
  end

  assign mcfg.pattern  = pattern_r;
  assign mcfg.care     = care_r;
  assign mcfg.len_eff  = len_eff;
  assign mcfg.all_wild = (length_r == '0);

  // --- handshake: the output register parts the two sides
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  // idle bytes without a first-byte mark are swallowed untouched
  assign active   = in_first_byte || !done_r;
  assign shift_en = in_fire && active;

  // --- window chain: cell 0 takes the new byte, the rest take the
  // neighbour's; a first byte flushes all but cell 0
  genvar g;
  generate
    for (g = 0; g < MAX_PATTERN; g++) begin : g_cell
      if (g == 0) begin : g_head
        assign cell_in[g] = in_data_byte;
      end else begin : g_body
        assign cell_in[g] = cell_q[g-1];
      end

      mbps_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .flush    ((g != 0) && in_first_byte),
        .idx      (IDX_W'(g)),
        .cfg      (mcfg),
        .byte_in  (cell_in[g]),
        .byte_q   (cell_q[g]),
        .ok       (cell_ok[g])
      );
    end
  endgenerate

  assign win_ok = &cell_ok;

  // --- byte count, saturating
  assign cnt_base = in_first_byte ? '0 : cnt_r;
  assign cnt_nxt  = (cnt_base == COUNT_MAX) ? cnt_base : cnt_base + CNT_W'(1);

  assign len_ext  = CNT_W'(len_eff);
  assign have_win = (cnt_nxt >= len_ext);
  assign start    = cnt_nxt - len_ext;
  assign start_p1 = {1'b0, start} + (CNT_W+1)'(1);
  assign in_limit = (start < CNT_W'(limit_r));

  assign hit  = have_win && in_limit && win_ok;
  // limit used up, nothing allowed, or region over
  assign miss = !hit && ((limit_r == '0) ||
                         (have_win && (start_p1 >= (CNT_W+1)'(limit_r))) ||
                         in_last_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b1;
    end else if (shift_en) begin
      cnt_r  <= cnt_nxt;
      done_r <= hit || miss;
    end
  end

  // --- result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (shift_en && (hit || miss)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en && (hit || miss)) begin
      found_r <= hit;
      addr_r  <= hit ? (base_r + ADDR_W'(start)) : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = found_r;
  assign out_match_address = addr_r;

endmodule

`default_nettype wire

### rtl/mbps_checker.sv
// ---------------------------------------------------------------------------
// mbps_checker
// Port-level checks on the pattern search, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "masked_byte_pattern_search_defines.svh"

module mbps_checker import mbps_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              out_found,
  input wire logic [ADDR_W-1:0] out_match_address
);

  // not-found words carry a zero address
  `MBPS_ASSERT_IMP(a_miss_zero, out_valid && !out_found, out_match_address == '0, "miss with nonzero address")

  // input only backs up behind a stalled result
  `MBPS_ASSERT_IMP(a_ready, !in_ready, out_valid && !out_ready, "in_ready low without output stall")

  // a result word appears only after a byte word was taken
  `MBPS_ASSERT_IMP(a_cause, $rose(out_valid), $past(in_valid && in_ready), "result without input")

  // stalled result holds
  `MBPS_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_found) && $stable(out_match_address), "stalled result changed")

endmodule

bind masked_byte_pattern_search mbps_checker u_mbps_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_found         (out_found),
  .out_match_address (out_match_address)
);

`default_nettype wire
